// ----- sv/tbdc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbdc_pkg
// Shared types, constants and the CRC-32C byte update for the transport
// block deframe checker.
// ---------------------------------------------------------------------------
`default_nettype none

package tbdc_pkg;

  localparam int MAX_FRAME_BYTES = 131072;

  localparam int POS_W    = 18;
  localparam int LEN_W    = 16;
  localparam int BLEN_W   = 17;
  localparam int CNT_W    = 19;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam int HDR_BYTES     = 32;
  localparam int HDR_CRC_START = 28;
  localparam int CRC_BYTES     = 4;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TRUNCATED = 4'd1,
    ST_BAD_TYPE  = 4'd2,
    ST_BAD_MINOR = 4'd3,
    ST_RESERVED  = 4'd4,
    ST_HDR_CRC   = 4'd5,
    ST_TRAILING  = 4'd6,
    ST_PAY_CRC   = 4'd7,
    ST_PADDING   = 4'd8,
    ST_TOO_LONG  = 4'd9
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PADDED_MODE    = 2'd0,
    REG_DATA_BLOCK_TYPE = 2'd1,
    REG_REQUIRED_MINOR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic       padded_mode;
    logic [7:0] data_block_type;
    logic [7:0] required_minor;
  } cfg_t;

  typedef struct packed {
    logic              is_verdict;
    logic [7:0]        payload_byte;
    status_t           status_code;
    logic [POS_W-1:0]  error_offset;
    logic [63:0]       session_tag;
    logic [63:0]       segment_ordinal;
    logic [31:0]       outer_block_id;
    logic [LEN_W-1:0]  payload_length;
  } res_t;

  // reflected castagnoli crc, one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tbdc_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbdc_in_if
// Byte stream channel into the deframe checker.
// ---------------------------------------------------------------------------
`default_nettype none

interface tbdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ----- sv/tbdc_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbdc_out_if
// Result channel: passed payload bytes and the frame verdict.
// ---------------------------------------------------------------------------
`default_nettype none

interface tbdc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_verdict;
  logic [7:0]                    payload_byte;
  logic [3:0]                    status_code;
  logic [tbdc_pkg::POS_W-1:0]    error_offset;
  logic [63:0]                   session_tag;
  logic [63:0]                   segment_ordinal;
  logic [31:0]                   outer_block_id;
  logic [tbdc_pkg::LEN_W-1:0]    payload_length;

  modport source (output valid, output is_verdict, output payload_byte,
                  output status_code, output error_offset, output session_tag,
                  output segment_ordinal, output outer_block_id,
                  output payload_length, input ready);
  modport sink   (input valid, input is_verdict, input payload_byte,
                  input status_code, input error_offset, input session_tag,
                  input segment_ordinal, input outer_block_id,
                  input payload_length, output ready);
endinterface

`default_nettype wire

// ----- sv/tbdc_parse.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbdc_parse
// Per-frame state: byte position, crc, header capture and first error.
// Consumes one accepted beat and produces at most one result.
// ---------------------------------------------------------------------------
`default_nettype none

module tbdc_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           beat_fire,
  input  wire logic [7:0]     data_byte,
  input  wire logic           end_of_frame,
  input  wire tbdc_pkg::cfg_t cfg,
  output logic                res_valid,
  output tbdc_pkg::res_t      res
);

  localparam int PW = tbdc_pkg::POS_W;
  localparam int BW = tbdc_pkg::BLEN_W;
  localparam int CW = tbdc_pkg::CNT_W;

  logic [PW-1:0]            pos_r,     pos_nxt;
  logic [31:0]              crc_r,     crc_nxt;
  logic [31:0]              hdr_crc_r, hdr_crc_nxt;
  logic [31:0]              crc_sh_r,  crc_sh_nxt;
  logic [63:0]              sess_r,    sess_nxt;
  logic [63:0]              ord_r,     ord_nxt;
  logic [31:0]              outer_r,   outer_nxt;
  logic [tbdc_pkg::LEN_W-1:0] len_r,   len_nxt;
  tbdc_pkg::status_t        err_r,     err_nxt;
  logic [PW-1:0]            eoff_r,    eoff_nxt;

  logic [BW-1:0]            pay_end;
  logic [BW-1:0]            blen;
  logic [CW-1:0]            count;
  logic                     in_hdr;
  logic                     in_pay;
  logic                     in_trl;
  logic                     note_en;
  tbdc_pkg::status_t        note_code;
  logic [PW-1:0]            note_off;
  tbdc_pkg::status_t        err_a;
  logic [PW-1:0]            eoff_a;
  logic [31:0]              crc_upd;
  logic [31:0]              sh_upd;
  tbdc_pkg::status_t        v_code;
  logic [PW-1:0]            v_off;

  assign pay_end = BW'(tbdc_pkg::HDR_BYTES) + {1'b0, len_r};
  assign blen    = pay_end + BW'(tbdc_pkg::CRC_BYTES);
  assign count   = {1'b0, pos_r} + CW'(1);
  assign in_hdr  = (pos_r < PW'(tbdc_pkg::HDR_BYTES));
  assign in_pay  = !in_hdr && (pos_r < {1'b0, pay_end});
  assign in_trl  = !in_hdr && !in_pay && (pos_r < {1'b0, blen});
  assign crc_upd = tbdc_pkg::crc32c_byte(crc_r, data_byte);
  assign sh_upd  = {data_byte, crc_sh_r[31:8]};

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    hdr_crc_nxt = hdr_crc_r;
    crc_sh_nxt  = crc_sh_r;
    sess_nxt    = sess_r;
    ord_nxt     = ord_r;
    outer_nxt   = outer_r;
    len_nxt     = len_r;
    note_en     = 1'b0;
    note_code   = tbdc_pkg::ST_OK;
    note_off    = '0;

    if (in_hdr) begin
      if (pos_r < PW'(tbdc_pkg::HDR_CRC_START)) begin
        crc_nxt = crc_upd;
      end
      if (pos_r == PW'(0) && data_byte != cfg.data_block_type) begin
        note_en   = 1'b1;
        note_code = tbdc_pkg::ST_BAD_TYPE;
        note_off  = PW'(0);
      end else if (pos_r == PW'(1) && data_byte != cfg.required_minor) begin
        note_en   = 1'b1;
        note_code = tbdc_pkg::ST_BAD_MINOR;
        note_off  = PW'(1);
      end else if ((pos_r == PW'(2) || pos_r == PW'(3)) && data_byte != 8'd0) begin
        note_en   = 1'b1;
        note_code = tbdc_pkg::ST_RESERVED;
        note_off  = PW'(2);
      end else if (pos_r >= PW'(4) && pos_r < PW'(12)) begin
        sess_nxt = {data_byte, sess_r[63:8]};
      end else if (pos_r >= PW'(12) && pos_r < PW'(20)) begin
        ord_nxt = {data_byte, ord_r[63:8]};
      end else if (pos_r >= PW'(20) && pos_r < PW'(24)) begin
        outer_nxt = {data_byte, outer_r[31:8]};
      end else if (pos_r >= PW'(24) && pos_r < PW'(26)) begin
        len_nxt = {data_byte, len_r[15:8]};
      end else if ((pos_r == PW'(26) || pos_r == PW'(27)) && data_byte != 8'd0) begin
        note_en   = 1'b1;
        note_code = tbdc_pkg::ST_RESERVED;
        note_off  = PW'(26);
      end else if (pos_r >= PW'(tbdc_pkg::HDR_CRC_START)) begin
        crc_sh_nxt = sh_upd;
      end
      // header crc closes at byte 27, payload crc starts fresh
      if (pos_r == PW'(27)) begin
        hdr_crc_nxt = ~crc_upd;
        crc_nxt     = tbdc_pkg::CRC_INIT;
      end
      if (pos_r == PW'(31) && sh_upd != hdr_crc_r) begin
        note_en   = 1'b1;
        note_code = tbdc_pkg::ST_HDR_CRC;
        note_off  = PW'(tbdc_pkg::HDR_CRC_START);
      end
    end else if (in_pay) begin
      crc_nxt = crc_upd;
    end else if (in_trl) begin
      crc_sh_nxt = sh_upd;
      if (pos_r == {1'b0, blen - BW'(1)} && sh_upd != ~crc_r) begin
        note_en   = 1'b1;
        note_code = tbdc_pkg::ST_PAY_CRC;
        note_off  = {1'b0, pay_end};
      end
    end else if (cfg.padded_mode && data_byte != 8'd0) begin
      note_en   = 1'b1;
      note_code = tbdc_pkg::ST_PADDING;
      note_off  = pos_r;
    end

    if (pos_r != '1) begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  // too long overrides, then the first noted error sticks
  always_comb begin
    err_a  = err_r;
    eoff_a = eoff_r;
    if (pos_r >= PW'(tbdc_pkg::MAX_FRAME_BYTES)) begin
      err_a  = tbdc_pkg::ST_TOO_LONG;
      eoff_a = PW'(tbdc_pkg::MAX_FRAME_BYTES);
    end
    err_nxt  = err_a;
    eoff_nxt = eoff_a;
    if (note_en && err_a == tbdc_pkg::ST_OK) begin
      err_nxt  = note_code;
      eoff_nxt = note_off;
    end
  end

  always_comb begin
    v_code = tbdc_pkg::ST_OK;
    v_off  = '0;
    if (err_nxt == tbdc_pkg::ST_TOO_LONG) begin
      v_code = err_nxt;
      v_off  = eoff_nxt;
    end else if (count < CW'(tbdc_pkg::HDR_BYTES)) begin
      v_code = tbdc_pkg::ST_TRUNCATED;
      v_off  = count[PW-1:0];
    end else if (err_nxt == tbdc_pkg::ST_BAD_TYPE || err_nxt == tbdc_pkg::ST_BAD_MINOR ||
                 err_nxt == tbdc_pkg::ST_RESERVED || err_nxt == tbdc_pkg::ST_HDR_CRC) begin
      v_code = err_nxt;
      v_off  = eoff_nxt;
    end else if (count < {2'b00, blen}) begin
      v_code = tbdc_pkg::ST_TRUNCATED;
      v_off  = count[PW-1:0];
    end else if (!cfg.padded_mode && count > {2'b00, blen}) begin
      v_code = tbdc_pkg::ST_TRAILING;
      v_off  = {1'b0, blen};
    end else if (err_nxt != tbdc_pkg::ST_OK) begin
      v_code = err_nxt;
      v_off  = eoff_nxt;
    end
  end

  assign res_valid = beat_fire && (end_of_frame || in_pay);

  always_comb begin
    res.is_verdict      = end_of_frame;
    res.payload_byte    = end_of_frame ? 8'd0 : data_byte;
    res.status_code     = end_of_frame ? v_code : tbdc_pkg::ST_OK;
    res.error_offset    = end_of_frame ? v_off : '0;
    res.session_tag     = sess_nxt;
    res.segment_ordinal = ord_nxt;
    res.outer_block_id  = outer_nxt;
    res.payload_length  = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_fire && end_of_frame)) begin
      pos_r     <= '0;
      crc_r     <= tbdc_pkg::CRC_INIT;
      hdr_crc_r <= '0;
      crc_sh_r  <= '0;
      sess_r    <= '0;
      ord_r     <= '0;
      outer_r   <= '0;
      len_r     <= '0;
      err_r     <= tbdc_pkg::ST_OK;
      eoff_r    <= '0;
    end else if (beat_fire) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      hdr_crc_r <= hdr_crc_nxt;
      crc_sh_r  <= crc_sh_nxt;
      sess_r    <= sess_nxt;
      ord_r     <= ord_nxt;
      outer_r   <= outer_nxt;
      len_r     <= len_nxt;
      err_r     <= err_nxt;
      eoff_r    <= eoff_nxt;
    end
  end

  // a closed frame starts again from offset zero with no error
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_fire && end_of_frame) |=> (pos_r == '0 && err_r == tbdc_pkg::ST_OK))
    else $error("frame state not cleared after last beat");

  // too long is never lost once the frame passes the limit
  a_too_long_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_fire && !end_of_frame && pos_r >= PW'(tbdc_pkg::MAX_FRAME_BYTES))
    |=> (err_r == tbdc_pkg::ST_TOO_LONG))
    else $error("too long error not held");

  // a result only ever comes from an accepted beat
  a_res_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> beat_fire)
    else $error("result without a beat");

endmodule

`default_nettype wire

// ----- sv/transport_block_deframe_check.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// transport_block_deframe_check
// Deframes a transport block byte stream, checks header and payload crc,
// passes payload bytes through and reports one verdict per frame.
// ---------------------------------------------------------------------------
// a result is registered into the output register in the cycle after its beat
// throughput: one byte per cycle while the output is not stalled, set by the byte-wide crc-32c update
// input accepts while the output register is empty or being drained
// reset (sync, active low): frame state cleared, crc all ones,
// padded_mode 1, data_block_type 1, required_minor 0, no clearing pass
`default_nettype none

module transport_block_deframe_check (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  tbdc_in_if.sink                                 in_ch,
  tbdc_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [tbdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tbdc_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  tbdc_pkg::cfg_t cfg_r;
  logic           in_ready;
  logic           beat_fire;
  logic           res_valid;
  tbdc_pkg::res_t res;
  logic           out_valid_r;
  tbdc_pkg::res_t out_r;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign beat_fire   = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.padded_mode     <= 1'b1;
      cfg_r.data_block_type <= 8'd1;
      cfg_r.required_minor  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tbdc_pkg::REG_PADDED_MODE:     cfg_r.padded_mode     <= cfg_wdata[0];
        tbdc_pkg::REG_DATA_BLOCK_TYPE: cfg_r.data_block_type <= cfg_wdata;
        tbdc_pkg::REG_REQUIRED_MINOR:  cfg_r.required_minor  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tbdc_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_fire    (beat_fire),
    .data_byte    (in_ch.data_byte),
    .end_of_frame (in_ch.end_of_frame),
    .cfg          (cfg_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.is_verdict      = out_r.is_verdict;
  assign out_ch.payload_byte    = out_r.payload_byte;
  assign out_ch.status_code     = out_r.status_code;
  assign out_ch.error_offset    = out_r.error_offset;
  assign out_ch.session_tag     = out_r.session_tag;
  assign out_ch.segment_ordinal = out_r.segment_ordinal;
  assign out_ch.outer_block_id  = out_r.outer_block_id;
  assign out_ch.payload_length  = out_r.payload_length;

  // last beat always yields a verdict beat next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_fire && in_ch.end_of_frame) |=> (out_valid_r && out_r.is_verdict))
    else $error("missing verdict after last beat");

  // payload beats carry no status
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.is_verdict)
    |-> (out_r.status_code == tbdc_pkg::ST_OK && out_r.error_offset == '0))
    else $error("payload beat with status");

  // an ok verdict reports offset zero
  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_verdict && out_r.status_code == tbdc_pkg::ST_OK)
    |-> (out_r.error_offset == '0))
    else $error("ok verdict with nonzero offset");

endmodule

`default_nettype wire
